// File: src/assert_macros.svh
// Assertion macros for the RTL files; the framer top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define BPF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bpf_pkg.sv
// Types, constants and the CRC-16 step shared by the packet framer.
package bpf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SYNC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLD_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLD_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLD_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLD_D = 3'd5;

  // Reset values of the registers
  localparam logic [BYTE_W-1:0] RST_SYNC  = 8'hFA;
  localparam logic [BYTE_W-1:0] RST_GROUP = 8'h39;
  localparam logic [WORD_W-1:0] RST_FLD_A = 16'h01E9;
  localparam logic [WORD_W-1:0] RST_FLD_B = 16'h061A;
  localparam logic [WORD_W-1:0] RST_FLD_C = 16'h0140;
  localparam logic [WORD_W-1:0] RST_FLD_D = 16'h0009;

  // Byte positions within one packet
  localparam logic [PHASE_W-1:0] PH_SYNC  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_GROUP = 4'd1;
  localparam logic [PHASE_W-1:0] PH_FAH   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_FAL   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_FBH   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_FBL   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_FCH   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_FCL   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_FDH   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_FDL   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_PAY   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_CRCH  = 4'd11;
  localparam logic [PHASE_W-1:0] PH_CRCL  = 4'd12;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] group_byte;
    logic [WORD_W-1:0] group_field_a;
    logic [WORD_W-1:0] group_field_b;
    logic [WORD_W-1:0] group_field_c;
    logic [WORD_W-1:0] group_field_d;
  } bpf_cfg_t;

  typedef struct packed {
    logic               job_v;
    logic               emit;
    logic               in_frame;
    logic               crc_zero;
    logic [PHASE_W-1:0] phase;
  } bpf_status_t;

  // Byte-wise CCITT update, zero-init form
  function automatic logic [WORD_W-1:0] crc16_step(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

// File: src/bpf_if.sv
// Handshake channel interfaces: payload input, packet output, register writes.
interface bpf_in_if;
  logic                      valid;
  logic                      ready;
  logic [bpf_pkg::BYTE_W-1:0] payload_byte;
  logic                      last_byte;
  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface bpf_out_if;
  logic                      valid;
  logic                      ready;
  logic [bpf_pkg::BYTE_W-1:0] out_byte;
  logic                      run_end;
  logic                      frame_end;
  modport source (output valid, output out_byte, output run_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input frame_end,
                  output ready);
endinterface

interface bpf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bpf_pkg::CFG_IDX_W-1:0] index;
  logic [bpf_pkg::WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/binary_packet_framer_crc16_core.sv
// Top level of the binary packet framer with CRC-16 trailer.
//
// Channels: in_ch takes one payload byte per request with a last-byte flag;
// out_ch delivers packet bytes with run_end (last byte caused by a request)
// and frame_end (low CRC byte); cfg_ch writes the six header registers,
// index 0 sync, 1 group, 2..5 group fields, and is always ready.
// The first request of a frame yields 10 header bytes, then the payload byte;
// a request flagged last adds the CRC high and low bytes. Every request
// gives 1 to 13 bytes, one per cycle from the byte sequencer while out_ch
// does not stall. A taken request is held in the request register and each
// byte goes out through the output register. Mid-frame payload bytes run back
// to back: a request is taken in the same cycle the previous one sends its
// final byte. A frame start holds the input while its header goes out.
// Reset (rst_n low, synchronous) restores register defaults, closes any frame
// and clears the CRC. When out_ch.ready is low with a byte held, the output
// register keeps its byte and the sequencer stops; in_ch.ready stays low while
// a request is held, except in the cycle it sends its final byte.
`include "assert_macros.svh"

module binary_packet_framer_crc16_core (
  input  logic      clk,
  input  logic      rst_n,
  bpf_in_if.sink    in_ch,
  bpf_out_if.source out_ch,
  bpf_cfg_if.sink   cfg_ch
);
  import bpf_pkg::*;

  bpf_cfg_t    regs;
  bpf_status_t st;

  bpf_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .regs  (regs)
  );

  bpf_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .regs   (regs),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .status (st)
  );

  `BPF_ASSERT_SAME(a_hdr_only_closed, st.emit && st.phase == PH_SYNC, !st.in_frame, "header sent inside an open frame")
  `BPF_ASSERT_NEXT(a_crc_close, st.emit && st.phase == PH_CRCL, !st.in_frame && st.crc_zero, "frame not closed after CRC")
  `BPF_ASSERT_SAME(a_phase_range, st.job_v, st.phase <= PH_CRCL, "sequencer phase out of range")
  `BPF_ASSERT_NEXT(a_busy_no_take, st.job_v && !st.emit, st.job_v, "request lost while stalled")

endmodule

// File: src/bpf_cfg_regs.sv
// Header configuration registers behind the write port.
module bpf_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  bpf_cfg_if.sink           cfg,
  output bpf_pkg::bpf_cfg_t regs
);
  import bpf_pkg::*;

  bpf_cfg_t regs_r;
  logic     wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.sync_byte     <= RST_SYNC;
      regs_r.group_byte    <= RST_GROUP;
      regs_r.group_field_a <= RST_FLD_A;
      regs_r.group_field_b <= RST_FLD_B;
      regs_r.group_field_c <= RST_FLD_C;
      regs_r.group_field_d <= RST_FLD_D;
    end else if (wr) begin
      unique case (cfg.index)
        REG_SYNC:  regs_r.sync_byte     <= cfg.data[BYTE_W-1:0];
        REG_GROUP: regs_r.group_byte    <= cfg.data[BYTE_W-1:0];
        REG_FLD_A: regs_r.group_field_a <= cfg.data;
        REG_FLD_B: regs_r.group_field_b <= cfg.data;
        REG_FLD_C: regs_r.group_field_c <= cfg.data;
        REG_FLD_D: regs_r.group_field_d <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// File: src/bpf_emit.sv
// Byte sequencer: holds one input request, walks its packet bytes, runs the CRC.
module bpf_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpf_pkg::bpf_cfg_t    regs,
  bpf_in_if.sink               in_ch,
  bpf_out_if.source            out_ch,
  output bpf_pkg::bpf_status_t status
);
  import bpf_pkg::*;

  // request register
  logic               job_v_r, job_v_nxt;
  logic [BYTE_W-1:0]  pay_r;
  logic               last_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  // frame state
  logic               in_frame_r, in_frame_nxt;
  logic [WORD_W-1:0]  crc_r, crc_nxt;
  // output register
  logic               out_v_r, out_v_nxt;
  logic [BYTE_W-1:0]  byte_r;
  logic               run_end_r, frame_end_r;

  logic [PHASE_W-1:0] ph;
  logic               emit, done, take;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_run_end, cur_frame_end;

  // a fresh request skips the header when a frame is already open
  assign ph   = (phase_r == PH_SYNC && in_frame_r) ? PH_PAY : phase_r;
  assign emit = job_v_r && (!out_v_r || out_ch.ready);
  assign done = (ph == PH_PAY && !last_r) || ph == PH_CRCL;
  assign in_ch.ready = !job_v_r || (emit && done);
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_byte      = '0;
    cur_run_end   = 1'b0;
    cur_frame_end = 1'b0;
    phase_nxt     = ph + 1'b1;
    crc_nxt       = crc16_step(crc_r, cur_byte);
    unique case (ph)
      PH_SYNC:  cur_byte = regs.sync_byte;
      PH_GROUP: cur_byte = regs.group_byte;
      PH_FAH:   cur_byte = regs.group_field_a[15:8];
      PH_FAL:   cur_byte = regs.group_field_a[7:0];
      PH_FBH:   cur_byte = regs.group_field_b[15:8];
      PH_FBL:   cur_byte = regs.group_field_b[7:0];
      PH_FCH:   cur_byte = regs.group_field_c[15:8];
      PH_FCL:   cur_byte = regs.group_field_c[7:0];
      PH_FDH:   cur_byte = regs.group_field_d[15:8];
      PH_FDL:   cur_byte = regs.group_field_d[7:0];
      PH_PAY: begin
        cur_byte    = pay_r;
        cur_run_end = !last_r;
      end
      PH_CRCH:  cur_byte = crc_r[15:8];
      PH_CRCL: begin
        cur_byte      = crc_r[7:0];
        cur_run_end   = 1'b1;
        cur_frame_end = 1'b1;
      end
      default: ;
    endcase
    unique case (ph)
      PH_SYNC: crc_nxt = '0;  // sync byte is outside the CRC
      PH_CRCH: crc_nxt = crc_r;
      PH_CRCL: crc_nxt = '0;
      default: crc_nxt = crc16_step(crc_r, cur_byte);
    endcase
  end

  always_comb begin
    job_v_nxt    = job_v_r;
    in_frame_nxt = in_frame_r;
    if (emit) begin
      if (ph == PH_SYNC) begin
        in_frame_nxt = 1'b1;
      end else if (ph == PH_CRCL) begin
        in_frame_nxt = 1'b0;
      end
      if (done) begin
        job_v_nxt = 1'b0;
      end
    end
    if (take) begin
      job_v_nxt = 1'b1;
    end
    out_v_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r    <= 1'b0;
      phase_r    <= PH_SYNC;
      in_frame_r <= 1'b0;
      crc_r      <= '0;
      out_v_r    <= 1'b0;
    end else begin
      job_v_r    <= job_v_nxt;
      in_frame_r <= in_frame_nxt;
      out_v_r    <= out_v_nxt;
      if (take) begin
        phase_r <= PH_SYNC;
      end else if (emit) begin
        phase_r <= phase_nxt;
      end
      if (emit) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pay_r  <= in_ch.payload_byte;
      last_r <= in_ch.last_byte;
    end
    if (emit) begin
      byte_r      <= cur_byte;
      run_end_r   <= cur_run_end;
      frame_end_r <= cur_frame_end;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.run_end   = run_end_r;
  assign out_ch.frame_end = frame_end_r;

  assign status.job_v    = job_v_r;
  assign status.emit     = emit;
  assign status.in_frame = in_frame_r;
  assign status.crc_zero = (crc_r == '0);
  assign status.phase    = ph;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the packet framer: predicts header, payload and CRC bytes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpf_pkg::*;

  localparam int unsigned HDR_BYTES    = 10;
  localparam int unsigned MAX_GAP      = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned RAND_ITEMS   = 440;
  localparam int unsigned PHASE_ITEMS  = 70;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
  // indexes past the register file, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_end;
    logic              frame_end;
  } pkt_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  bpf_in_if  in_ch();
  bpf_out_if out_ch();
  bpf_cfg_if cfg_ch();

  binary_packet_framer_crc16_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  bpf_cfg_t          hdr_regs;
  logic              frame_open;
  logic [WORD_W-1:0] crc_run;
  pkt_byte_t         packet_q[$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_len     = 0;
  bit          idle_on      = 1'b1;

  always begin
    #2ns clk = 1'b1;
    #2ns clk = 1'b0;
  end

  // bit-serial CCITT, MSB first, no final xor
  function automatic logic [WORD_W-1:0] crc_ccitt_byte(input logic [WORD_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[WORD_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic void frame_bytes(input logic [BYTE_W-1:0] pb, input logic last);
    logic [8*HDR_BYTES-1:0] hdr;
    logic [BYTE_W-1:0]      hb;
    if (!frame_open) begin
      hdr = {hdr_regs.sync_byte, hdr_regs.group_byte, hdr_regs.group_field_a,
             hdr_regs.group_field_b, hdr_regs.group_field_c, hdr_regs.group_field_d};
      crc_run = '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hb = hdr[8*(HDR_BYTES-1-i) +: 8];
        packet_q.push_back({hb, 1'b0, 1'b0});
        // sync byte stays out of the CRC
        if (i != 0)
          crc_run = crc_ccitt_byte(crc_run, hb);
      end
      frame_open = 1'b1;
    end
    crc_run = crc_ccitt_byte(crc_run, pb);
    packet_q.push_back({pb, !last, 1'b0});
    if (last) begin
      packet_q.push_back({crc_run[15:8], 1'b0, 1'b0});
      packet_q.push_back({crc_run[7:0], 1'b1, 1'b1});
      crc_run    = '0;
      frame_open = 1'b0;
    end
  endfunction

  function automatic int unsigned pick_gap();
    if (!idle_on || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(1, MAX_GAP);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    if (mismatches < MAX_PRINTS)
      $display("tb: %0t %s mismatch: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    pkt_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (packet_q.size() == 0) begin
        report_mismatch("unexpected byte", out_ch.out_byte, '0);
      end else begin
        want = packet_q.pop_front();
        if (out_ch.out_byte !== want.data)
          report_mismatch("out_byte", out_ch.out_byte, want.data);
        if (out_ch.run_end !== want.run_end)
          report_mismatch("run_end", BYTE_W'(out_ch.run_end), BYTE_W'(want.run_end));
        if (out_ch.frame_end !== want.frame_end)
          report_mismatch("frame_end", BYTE_W'(out_ch.frame_end), BYTE_W'(want.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // output side: random stall before each byte, plus a long hold on demand
  initial begin : drain_side
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_len > 0) begin
        repeat (hold_len) begin
          @(negedge clk);
          out_ch.ready = 1'b0;
        end
        hold_len = 0;
      end
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_byte(input logic [BYTE_W-1:0] pb, input logic last);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.payload_byte = pb;
    in_ch.last_byte    = last;
    do @(posedge clk); while (!in_ch.ready);
    frame_bytes(pb, last);
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++)
      send_byte(BYTE_W'($urandom), i == len);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (packet_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SYNC:  hdr_regs.sync_byte     = val[BYTE_W-1:0];
      REG_GROUP: hdr_regs.group_byte    = val[BYTE_W-1:0];
      REG_FLD_A: hdr_regs.group_field_a = val;
      REG_FLD_B: hdr_regs.group_field_b = val;
      REG_FLD_C: hdr_regs.group_field_c = val;
      REG_FLD_D: hdr_regs.group_field_d = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // upper data bits on the byte registers are junk the block must drop
  task automatic program_header(input bpf_cfg_t v);
    write_reg(REG_SYNC,  {BYTE_W'($urandom), v.sync_byte});
    write_reg(REG_GROUP, {BYTE_W'($urandom), v.group_byte});
    write_reg(REG_FLD_A, v.group_field_a);
    write_reg(REG_FLD_B, v.group_field_b);
    write_reg(REG_FLD_C, v.group_field_c);
    write_reg(REG_FLD_D, v.group_field_d);
  endtask

  // ---------------- tests ----------------
  task automatic test_default_header();
    send_frame(1);
    send_frame(3);
  endtask

  task automatic test_header_extremes();
    wait_drained();
    program_header('0);
    send_byte(8'h00, 1'b1);
    wait_drained();
    program_header('1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
    write_reg(REG_SPARE_6, pick_word());
    write_reg(REG_SPARE_7, pick_word());
    send_frame(2);
    send_frame(1);
    send_frame(1);
  endtask

  // header goes out with the first request, so a write inside a frame hits the next one
  task automatic test_midframe_write();
    send_byte(8'h5A, 1'b0);
    wait_drained();
    write_reg(REG_GROUP, 16'h1234);
    write_reg(REG_FLD_C, 16'hBEEF);
    send_byte(8'hA5, 1'b1);
    send_frame(2);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned next_phase;
    int unsigned len;
    bpf_cfg_t    hdr;
    sent       = 0;
    next_phase = 0;
    while (sent < n_items) begin
      if (sent >= next_phase) begin
        wait_drained();
        hdr = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
        hdr.sync_byte = BYTE_W'(pick_word());
        program_header(hdr);
        if ($urandom_range(0, 2) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, pick_word());
        // some phases run with no idling on either side
        idle_on    = ($urandom_range(0, 3) != 0);
        next_phase = sent + PHASE_ITEMS;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
      if ($urandom_range(0, 4) == 0) begin
        for (int unsigned i = 0; i < len; i++)
          send_byte(BYTE_W'($urandom), $urandom_range(0, 2) == 0);
      end else begin
        send_frame(len);
      end
      sent += len;
    end
    idle_on = 1'b1;
  endtask

  // sink stalls for a long stretch while requests keep coming back to back
  task automatic test_output_hold();
    wait_drained();
    idle_on  = 1'b0;
    hold_len = HOLD_CYCLES;
    send_frame(40);
    idle_on  = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.last_byte    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_SYNC;
    cfg_ch.data        = '0;
    hdr_regs   = {RST_SYNC, RST_GROUP, RST_FLD_A, RST_FLD_B, RST_FLD_C, RST_FLD_D};
    frame_open = 1'b0;
    crc_run    = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_default_header();
    test_header_extremes();
    test_midframe_write();
    test_random_traffic(RAND_ITEMS);
    test_output_hold();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/bpf_pkg.sv
src/bpf_if.sv
src/bpf_cfg_regs.sv
src/bpf_emit.sv
src/binary_packet_framer_crc16_core.sv
dv/tb.sv
